@@ hdl/button_press_classifier_defines.svh @@
// Assertion macros for the button press classifier.
// Included by modules that check their own logic; depends on nothing.
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bpc_pkg.sv @@
// Shared types, codes and reset values of the button press classifier.
// Used by button_press_classifier; depends on nothing.
package bpc_pkg;

    // Default width of the tick clock and deadlines
    localparam int TIME_BITS_DEFAULT = 32;

    // Input commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_GATE  = 2'd1,
        CMD_BLOCK = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // Reported events
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_REPEAT = 2'd3
    } t_event;

    // Press modes
    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_LONG   = 2'd1,
        MODE_REPEAT = 2'd2,
        MODE_SPARE  = 2'd3
    } t_mode;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_IDLE_LEVEL    = 3'd0,
        REG_PRESS_MODE    = 3'd1,
        REG_REPEAT_DELAY  = 3'd2,
        REG_REPEAT_PERIOD = 3'd3,
        REG_LONG_DELAY    = 3'd4,
        REG_LOCKOUT_TIME  = 3'd5,
        REG_PRIMARY       = 3'd6,
        REG_SECONDARY     = 3'd7
    } t_reg_idx;

    // Configuration reset values
    localparam logic        RST_IDLE_LEVEL    = 1'b1;
    localparam logic [15:0] RST_REPEAT_DELAY  = 16'd500;
    localparam logic [15:0] RST_REPEAT_PERIOD = 16'd100;
    localparam logic [15:0] RST_LONG_DELAY    = 16'd1000;
    localparam logic [15:0] RST_LOCKOUT_TIME  = 16'd200;

endpackage

@@ hdl/button_press_classifier.sv @@
// Top level of the button press classifier: tick clock, edge detection,
// deadlines and result register. Depends on bpc_pkg and
// button_press_classifier_defines.svh.

// One button, sampled by tick items on the input stream. The state update
// and event decision are a single combinational pass of increment,
// TIME_BITS-wide compares and saturating adds between the state registers
// and the one-entry result register, so an item is accepted in every
// cycle in which the result register is empty or being drained.
// Tick items (tuser 0) advance the tick clock and may report one short
// press, long press or repeat on the output stream; gate (tuser 1) and
// block (tuser 2) items only change long press state and report nothing.
// Configuration writes are taken in any cycle (o_cfg_ready is always high)
// and must only be issued while the block is idle.
`include "button_press_classifier_defines.svh"

module button_press_classifier #(
    parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [0] level, [16:1] timeout_ticks, [23:17] zero
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] command
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [7:0] action
    output logic [1:0]  o_m_axis_tuser,  // [1:0] event_res
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [TIME_BITS:0]   t_time_ext;

    // Saturating add of a 16-bit delay to a time
    function automatic t_time add_sat(input t_time a, input logic [15:0] d);
        t_time_ext sum;
        sum = t_time_ext'(a) + t_time_ext'(d);
        return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    endfunction

    // Configuration registers
    logic          r_idle_level;
    bpc_pkg::t_mode r_press_mode;
    logic [15:0]   r_repeat_delay;
    logic [15:0]   r_repeat_period;
    logic [15:0]   r_long_delay;
    logic [15:0]   r_lockout_time;
    logic [7:0]    r_primary;
    logic [7:0]    r_secondary;

    // Classifier state
    t_time r_now, n_now;
    logic  r_last_level, n_last_level;
    logic  r_held, n_held;
    t_time r_repeat_due, n_repeat_due;
    t_time r_long_due, n_long_due;
    t_time r_unlock_at, n_unlock_at;
    logic  r_long_taken, n_long_taken;
    t_time r_gate_until, n_gate_until;

    // Result register
    logic              r_out_valid;
    bpc_pkg::t_event   r_out_event;
    logic [7:0]        r_out_action;
    bpc_pkg::t_event   n_event;
    logic [7:0]        n_action;

    logic          s_accept;
    bpc_pkg::t_cmd in_cmd;
    logic          in_level;
    logic [15:0]   in_timeout;
    t_time         now_inc;
    logic [15:0]   period_m1;
    logic          is_release;
    logic          is_press;
    logic          block_ready;

    assign in_cmd     = bpc_pkg::t_cmd'(i_s_axis_tuser);
    assign in_level   = i_s_axis_tdata[0];
    assign in_timeout = i_s_axis_tdata[16:1];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Apply configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_level    <= bpc_pkg::RST_IDLE_LEVEL;
            r_press_mode    <= bpc_pkg::MODE_PLAIN;
            r_repeat_delay  <= bpc_pkg::RST_REPEAT_DELAY;
            r_repeat_period <= bpc_pkg::RST_REPEAT_PERIOD;
            r_long_delay    <= bpc_pkg::RST_LONG_DELAY;
            r_lockout_time  <= bpc_pkg::RST_LOCKOUT_TIME;
            r_primary       <= '0;
            r_secondary     <= '0;
        end else if (i_cfg_valid) begin
            unique case (bpc_pkg::t_reg_idx'(i_cfg_index))
                bpc_pkg::REG_IDLE_LEVEL:    r_idle_level    <= i_cfg_data[0];
                bpc_pkg::REG_PRESS_MODE:    r_press_mode    <= bpc_pkg::t_mode'(i_cfg_data[1:0]);
                bpc_pkg::REG_REPEAT_DELAY:  r_repeat_delay  <= i_cfg_data;
                bpc_pkg::REG_REPEAT_PERIOD: r_repeat_period <= i_cfg_data;
                bpc_pkg::REG_LONG_DELAY:    r_long_delay    <= i_cfg_data;
                bpc_pkg::REG_LOCKOUT_TIME:  r_lockout_time  <= i_cfg_data;
                bpc_pkg::REG_PRIMARY:       r_primary       <= i_cfg_data[7:0];
                bpc_pkg::REG_SECONDARY:     r_secondary     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Shared terms of the decision
    assign now_inc     = r_now + t_time'(1);
    assign period_m1   = (r_repeat_period == 16'd0) ? 16'd0 : r_repeat_period - 16'd1;
    assign is_release  = (r_last_level != r_idle_level) && (in_level == r_idle_level);
    assign is_press    = (r_last_level == r_idle_level) && (in_level != r_idle_level);
    assign block_ready = (r_press_mode == bpc_pkg::MODE_LONG) && r_held &&
                         (r_now > r_long_due) && !r_long_taken && (r_now > r_unlock_at);

    // Compute next state and the event for the offered item
    always_comb begin
        n_now        = r_now;
        n_last_level = r_last_level;
        n_held       = r_held;
        n_repeat_due = r_repeat_due;
        n_long_due   = r_long_due;
        n_unlock_at  = r_unlock_at;
        n_long_taken = r_long_taken;
        n_gate_until = r_gate_until;
        n_event      = bpc_pkg::EV_NONE;
        n_action     = '0;
        unique case (in_cmd)
            bpc_pkg::CMD_GATE: begin
                n_gate_until = add_sat(r_now, in_timeout);
            end
            bpc_pkg::CMD_BLOCK: begin
                if (block_ready) begin
                    n_long_taken = 1'b1;
                    n_unlock_at  = add_sat(r_now, r_lockout_time);
                end
            end
            bpc_pkg::CMD_TICK: begin
                n_now        = now_inc;
                n_last_level = in_level;
                // release edge: short press unless a long press owned this hold or the lockout is running
                if (is_release) begin
                    n_held = 1'b0;
                    if (r_long_taken) begin
                        n_long_taken = 1'b0;
                    end else if (now_inc > r_unlock_at) begin
                        n_event  = bpc_pkg::EV_SHORT;
                        n_action = r_primary;
                    end
                end
                // press edge: arm deadlines
                if (is_press) begin
                    n_held       = 1'b1;
                    n_repeat_due = add_sat(now_inc, r_repeat_delay);
                    n_long_due   = add_sat(now_inc, r_long_delay);
                end
                // long press once per hold, gated by the gate item's timeout and the lockout
                if (n_event == bpc_pkg::EV_NONE && r_press_mode == bpc_pkg::MODE_LONG &&
                    n_held && now_inc > n_long_due && !n_long_taken &&
                    now_inc > r_unlock_at && now_inc > r_gate_until) begin
                    n_gate_until = '0;
                    n_long_taken = 1'b1;
                    n_event      = bpc_pkg::EV_LONG;
                    n_action     = r_secondary;
                end
                // auto repeat
                if (n_event == bpc_pkg::EV_NONE && r_press_mode == bpc_pkg::MODE_REPEAT &&
                    n_held && now_inc > n_repeat_due) begin
                    n_repeat_due = add_sat(now_inc, period_m1);
                    n_event      = bpc_pkg::EV_REPEAT;
                    n_action     = r_primary;
                end
                // every reported event starts the lockout
                if (n_event != bpc_pkg::EV_NONE) begin
                    n_unlock_at = add_sat(now_inc, r_lockout_time);
                end
            end
            default: ;
        endcase
    end

    // Advance state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now        <= '0;
            r_last_level <= 1'b1;
            r_held       <= 1'b0;
            r_repeat_due <= '0;
            r_long_due   <= '0;
            r_unlock_at  <= '0;
            r_long_taken <= 1'b0;
            r_gate_until <= '0;
        end else if (s_accept) begin
            r_now        <= n_now;
            r_last_level <= n_last_level;
            r_held       <= n_held;
            r_repeat_due <= n_repeat_due;
            r_long_due   <= n_long_due;
            r_unlock_at  <= n_unlock_at;
            r_long_taken <= n_long_taken;
            r_gate_until <= n_gate_until;
        end
    end

    // Hold the result until the downstream transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept && n_event != bpc_pkg::EV_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && n_event != bpc_pkg::EV_NONE) begin
            r_out_event  <= n_event;
            r_out_action <= n_action;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_action;
    assign o_m_axis_tuser  = r_out_event;

    // Checks on the classifier's own logic
    `BPC_ASSERT_IMP(a_out_has_event, r_out_valid, r_out_event != bpc_pkg::EV_NONE,
        "result register holds no event")
    `BPC_ASSERT_IMP(a_taken_needs_hold, r_long_taken, r_held,
        "long press taken while button is up")
    `BPC_ASSERT_NXT(a_non_tick_keeps_clock, s_accept && in_cmd != bpc_pkg::CMD_TICK,
        $stable(r_now), "tick clock moved on a non-tick command")
    `BPC_ASSERT_NXT(a_tick_advances_clock, s_accept && in_cmd == bpc_pkg::CMD_TICK,
        r_now == t_time'($past(r_now) + t_time'(1)), "tick clock did not advance by one")

endmodule
